/* hw/rtl/fdc_pkg.sv */
// ----------------------------------------------------------------------------
// fdc_pkg
// Shared widths, constants and request/response types for the divisor count
// of n factorial.
// ----------------------------------------------------------------------------
package fdc_pkg;

    // Width of n and of everything that never exceeds n
    localparam int N_W         = 8;
    // Largest n handled, larger inputs are clamped to it
    localparam int MAX_N       = 255;
    // Sieve flag store depth, one flag per possible n
    localparam int FLAG_DEPTH  = 2 ** N_W;
    // Sieve index and prime counters: one bit over n so they can step past it
    localparam int IDX_W       = N_W + 1;
    localparam int SQ_W        = 2 * IDX_W;
    // Running product and its (exponent + 1) factor
    localparam int PROD_W      = 64;
    localparam int FAC_W       = N_W;
    localparam int ACC_W       = PROD_W + FAC_W;
    // Step counters of the shared units
    localparam int DIV_CNT_W   = $clog2(N_W);
    localparam int MUL_CNT_W   = $clog2(FAC_W);
    // Stream payload widths
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 72;

    // Divider request: start pulse with dividend and divisor
    typedef struct packed {
        logic           start;
        logic [N_W-1:0] dividend;
        logic [N_W-1:0] divisor;
    } t_div_req;

    // Divider response: busy flag, done pulse and quotient
    typedef struct packed {
        logic           busy;
        logic           done;
        logic [N_W-1:0] quotient;
    } t_div_rsp;

    // Multiplier request: start pulse with operands
    typedef struct packed {
        logic              start;
        logic [PROD_W-1:0] multiplicand;
        logic [FAC_W-1:0]  factor;
    } t_mul_req;

    // Multiplier response: busy flag, done pulse, low product word and overflow mark
    typedef struct packed {
        logic              busy;
        logic              done;
        logic              overflow;
        logic [PROD_W-1:0] product;
    } t_mul_rsp;

endpackage

/* hw/rtl/fdc_divider.sv */
// ----------------------------------------------------------------------------
// fdc_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fdc_divider (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fdc_pkg::t_div_req i_req,
    output fdc_pkg::t_div_rsp o_rsp
);

    logic [fdc_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic [fdc_pkg::N_W-1:0]       r_rem;
    logic [fdc_pkg::N_W-1:0]       r_quo;
    logic [fdc_pkg::N_W-1:0]       r_dvs;

    logic [fdc_pkg::N_W:0]         w_trial;
    logic [fdc_pkg::N_W:0]         w_diff;
    logic                          w_ge;

    // Trial subtraction of the shifted remainder
    always_comb begin
        w_trial = {r_rem, r_quo[fdc_pkg::N_W-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        w_ge    = (w_trial >= {1'b0, r_dvs});
    end

    // Step sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == fdc_pkg::DIV_CNT_W'(fdc_pkg::N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[fdc_pkg::N_W-1:0] : w_trial[fdc_pkg::N_W-1:0];
            r_quo <= {r_quo[fdc_pkg::N_W-2:0], w_ge};
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

/* hw/rtl/fdc_multiplier.sv */
// ----------------------------------------------------------------------------
// fdc_multiplier
// Shift-and-add multiplier, 64 by 8 bits, one factor bit per cycle, with
// overflow detection above 64 bits.
// ----------------------------------------------------------------------------
module fdc_multiplier (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  fdc_pkg::t_mul_req i_req,
    output fdc_pkg::t_mul_rsp o_rsp
);

    logic [fdc_pkg::MUL_CNT_W-1:0] r_cnt;
    logic                          r_busy;
    logic                          r_done;
    logic [fdc_pkg::PROD_W-1:0]    r_mcand;
    logic [fdc_pkg::FAC_W-1:0]     r_fac;
    logic [fdc_pkg::ACC_W-1:0]     r_acc;

    logic [fdc_pkg::ACC_W-1:0]     w_addend;
    logic [fdc_pkg::ACC_W-1:0]     w_sum;

    // Accumulate, factor taken MSB first
    always_comb begin
        w_addend = r_fac[fdc_pkg::FAC_W-1] ?
                   {{fdc_pkg::FAC_W{1'b0}}, r_mcand} : '0;
        w_sum    = {r_acc[fdc_pkg::ACC_W-2:0], 1'b0} + w_addend;
    end

    // Step sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == fdc_pkg::MUL_CNT_W'(fdc_pkg::FAC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and accumulator registers
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mcand <= i_req.multiplicand;
            r_fac   <= i_req.factor;
            r_acc   <= '0;
        end else if (r_busy) begin
            r_fac <= {r_fac[fdc_pkg::FAC_W-2:0], 1'b0};
            r_acc <= w_sum;
        end
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.overflow = |r_acc[fdc_pkg::ACC_W-1:fdc_pkg::PROD_W];
    assign o_rsp.product  = r_acc[fdc_pkg::PROD_W-1:0];

endmodule

/* hw/rtl/factorial_divisor_count_top.sv */
// Work per request: clearing the flags of 0..n, marking the multiples of each prime up
// to sqrt(n), a read and a check per candidate, then for each prime one division per
// quotient and, while unsaturated, one multiply; 1 result per request.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: synchronous, active low; clears the sequencer, output valid and unit step control only.
// ----------------------------------------------------------------------------
// factorial_divisor_count_top
// Counts the divisors of n factorial: sieve of Eratosthenes into a flag
// memory, Legendre exponents through a shared divider, and the product of
// (exponent + 1) through a shared multiplier, saturating at 64 bits.
// ----------------------------------------------------------------------------
module factorial_divisor_count_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Request side
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [fdc_pkg::IN_TDATA_W-1:0]     i_s_tdata,  // [7:0] n_value
    // Result side
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [fdc_pkg::OUT_TDATA_W-1:0]    o_m_tdata   // [63:0] divisor_count,
                                                           // [64] overflowed, [71:65] zero
);

    typedef enum logic [9:0] {
        S_IDLE      = 10'b00_0000_0001,
        S_CLEAR     = 10'b00_0000_0010,
        S_SIEVE_RD  = 10'b00_0000_0100,
        S_SIEVE_CHK = 10'b00_0000_1000,
        S_MARK      = 10'b00_0001_0000,
        S_SCAN_RD   = 10'b00_0010_0000,
        S_SCAN_CHK  = 10'b00_0100_0000,
        S_DIV_WAIT  = 10'b00_1000_0000,
        S_MUL_WAIT  = 10'b01_0000_0000,
        S_DONE      = 10'b10_0000_0000
    } t_state;

    t_state                      r_state, n_state;
    logic [fdc_pkg::N_W-1:0]     r_n, n_n;
    logic [fdc_pkg::IDX_W-1:0]   r_idx, n_idx;
    logic [fdc_pkg::IDX_W-1:0]   r_p, n_p;
    logic [fdc_pkg::N_W-1:0]     r_e, n_e;
    logic [fdc_pkg::PROD_W-1:0]  r_prod, n_prod;
    logic                        r_sat, n_sat;
    logic                        r_out_valid, n_out_valid;
    logic [fdc_pkg::PROD_W-1:0]  r_out_count, n_out_count;
    logic                        r_out_ovf, n_out_ovf;

    // Sieve flag memory
    logic                        flag_mem [0:fdc_pkg::FLAG_DEPTH-1];
    logic                        w_wr_en;
    logic [fdc_pkg::N_W-1:0]     w_wr_addr;
    logic                        w_wr_data;
    logic                        w_rd_en;
    logic [fdc_pkg::N_W-1:0]     w_rd_addr;
    logic                        r_rd_data;

    logic [fdc_pkg::SQ_W-1:0]    w_p_sq;
    logic [fdc_pkg::N_W-1:0]     w_n_in;

    fdc_pkg::t_div_req           div_req;
    fdc_pkg::t_div_rsp           div_rsp;
    fdc_pkg::t_mul_req           mul_req;
    fdc_pkg::t_mul_rsp           mul_rsp;

    // Shared arithmetic units
    fdc_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    fdc_multiplier u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    // Flag memory, registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            flag_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= flag_mem[w_rd_addr];
        end
    end

    // Clamp n and square the sieve prime
    always_comb begin
        w_n_in = (32'(i_s_tdata) > fdc_pkg::MAX_N) ?
                 fdc_pkg::N_W'(fdc_pkg::MAX_N) : i_s_tdata[fdc_pkg::N_W-1:0];
        w_p_sq = r_p * r_p;
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_idx       = r_idx;
        n_p         = r_p;
        n_e         = r_e;
        n_prod      = r_prod;
        n_sat       = r_sat;
        n_out_valid = r_out_valid;
        n_out_count = r_out_count;
        n_out_ovf   = r_out_ovf;

        w_wr_en     = 1'b0;
        w_wr_addr   = r_idx[fdc_pkg::N_W-1:0];
        w_wr_data   = 1'b0;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_p[fdc_pkg::N_W-1:0];

        div_req.start        = 1'b0;
        div_req.dividend     = r_n;
        div_req.divisor      = r_p[fdc_pkg::N_W-1:0];
        mul_req.start        = 1'b0;
        mul_req.multiplicand = r_prod;
        mul_req.factor       = r_e + 1'b1;

        // Result taken downstream
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_n     = w_n_in;
                    n_idx   = '0;
                    n_prod  = fdc_pkg::PROD_W'(1);
                    n_sat   = 1'b0;
                    n_state = S_CLEAR;
                end
            end
            // Flags 0..n: set from 2 up
            S_CLEAR: begin
                w_wr_en   = 1'b1;
                w_wr_data = (r_idx >= fdc_pkg::IDX_W'(2));
                if (r_idx == {1'b0, r_n}) begin
                    n_p     = fdc_pkg::IDX_W'(2);
                    n_state = S_SIEVE_RD;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_SIEVE_RD: begin
                if (w_p_sq > fdc_pkg::SQ_W'(r_n)) begin
                    n_p     = fdc_pkg::IDX_W'(2);
                    n_state = S_SCAN_RD;
                end else begin
                    w_rd_en = 1'b1;
                    n_state = S_SIEVE_CHK;
                end
            end
            S_SIEVE_CHK: begin
                if (r_rd_data) begin
                    n_idx   = {r_p[fdc_pkg::IDX_W-2:0], 1'b0};
                    n_state = S_MARK;
                end else begin
                    n_p     = r_p + 1'b1;
                    n_state = S_SIEVE_RD;
                end
            end
            // Clear multiples of p from 2p up to n
            S_MARK: begin
                if (r_idx > {1'b0, r_n}) begin
                    n_p     = r_p + 1'b1;
                    n_state = S_SIEVE_RD;
                end else begin
                    w_wr_en = 1'b1;
                    n_idx   = r_idx + r_p;
                end
            end
            S_SCAN_RD: begin
                if (r_p > {1'b0, r_n}) begin
                    n_state = S_DONE;
                end else begin
                    w_rd_en = 1'b1;
                    n_state = S_SCAN_CHK;
                end
            end
            // Prime found: first quotient n / p; otherwise on to the next candidate
            S_SCAN_CHK: begin
                if (r_rd_data) begin
                    n_e           = '0;
                    div_req.start = 1'b1;
                    n_state       = S_DIV_WAIT;
                end else begin
                    n_p     = r_p + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            // Legendre sum: keep dividing the quotient by p until zero, then multiply unless saturated
            S_DIV_WAIT: begin
                if (div_rsp.done) begin
                    if (div_rsp.quotient == '0) begin
                        if (r_sat) begin
                            n_p     = r_p + 1'b1;
                            n_state = S_SCAN_RD;
                        end else begin
                            mul_req.start = 1'b1;
                            n_state       = S_MUL_WAIT;
                        end
                    end else begin
                        n_e              = r_e + div_rsp.quotient;
                        div_req.start    = 1'b1;
                        div_req.dividend = div_rsp.quotient;
                    end
                end
            end
            // Fold (e + 1) into the product, saturate on overflow
            S_MUL_WAIT: begin
                if (mul_rsp.done) begin
                    if (mul_rsp.overflow) begin
                        n_prod = '1;
                        n_sat  = 1'b1;
                    end else begin
                        n_prod = mul_rsp.product;
                    end
                    n_p     = r_p + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_count = r_prod;
                    n_out_ovf   = r_sat;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result registers
    always_ff @(posedge i_clk) begin
        r_n         <= n_n;
        r_idx       <= n_idx;
        r_p         <= n_p;
        r_e         <= n_e;
        r_prod      <= n_prod;
        r_sat       <= n_sat;
        r_out_count <= n_out_count;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(fdc_pkg::OUT_TDATA_W - fdc_pkg::PROD_W - 1){1'b0}},
                         r_out_ovf, r_out_count};

`ifndef SYNTHESIS
    // Divider and multiplier are never in use together
    a_units_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(div_rsp.busy && mul_rsp.busy))
        else $error("divider and multiplier busy together");

    // An accepted request always starts the flag clearing pass
    a_accept_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == S_CLEAR))
        else $error("request accepted without starting the clear pass");

    // A saturated result carries an all-ones count
    a_sat_all_ones: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[fdc_pkg::PROD_W]) |-> (&o_m_tdata[fdc_pkg::PROD_W-1:0]))
        else $error("overflow flagged without saturated count");
`endif

endmodule

/* dv/fdc_checker.sv */
// ----------------------------------------------------------------------------
// fdc_checker
// Watches the request and result streams of the factorial divisor counter.
// Predicts the divisor count of n! for each accepted request (sieve, then
// Legendre exponents, then a saturating product) and compares every result
// field with the oldest prediction still pending.
// ----------------------------------------------------------------------------
module fdc_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Request side, as seen on the wire
    input  logic                               i_s_tvalid,
    input  logic                               i_s_tready,
    input  logic [fdc_pkg::IN_TDATA_W-1:0]     i_s_tdata,   // [7:0] n_value
    // Result side, as seen on the wire
    input  logic                               i_m_tvalid,
    input  logic                               i_m_tready,
    input  logic [fdc_pkg::OUT_TDATA_W-1:0]    i_m_tdata,   // [63:0] divisor_count,
                                                            // [64] overflowed, [71:65] zero
    output int                                 o_error_count,
    output int                                 o_outstanding
);

    // One predicted result, tagged with the n that caused it
    typedef struct {
        logic [fdc_pkg::N_W-1:0]    n;
        logic [fdc_pkg::PROD_W-1:0] count;
        logic                       saturated;
    } t_divisor_result;

    t_divisor_result divisor_counts_q[$];

    initial begin
        o_error_count = 0;
        o_outstanding = 0;
    end

    // Divisors of n!: product of (exponent + 1) over primes p <= n,
    // exponent by Legendre, product saturating at all ones
    function automatic t_divisor_result divisors_of_factorial(
        input logic [fdc_pkg::N_W-1:0] n_in);
        bit                         composite [0:fdc_pkg::MAX_N];
        int unsigned                n;
        int unsigned                p;
        int unsigned                k;
        int unsigned                p_pow;
        int unsigned                expo;
        logic [fdc_pkg::PROD_W-1:0] factor;
        logic [fdc_pkg::PROD_W-1:0] prod;
        logic                       sat;
        t_divisor_result            res;
        n    = (n_in > fdc_pkg::MAX_N) ? fdc_pkg::MAX_N : n_in;
        prod = 1;
        sat  = 1'b0;
        for (k = 0; k <= fdc_pkg::MAX_N; k++)
            composite[k] = 1'b0;
        // strike out the multiples of each prime up to sqrt(n)
        for (p = 2; p * p <= n; p++) begin
            if (!composite[p]) begin
                for (k = 2 * p; k <= n; k += p)
                    composite[k] = 1'b1;
            end
        end
        for (p = 2; p <= n; p++) begin
            if (composite[p])
                continue;
            expo  = 0;
            p_pow = p;
            while (p_pow <= n) begin
                expo  += n / p_pow;
                p_pow *= p;
            end
            factor = fdc_pkg::PROD_W'(expo + 1);
            if (!sat) begin
                if (prod > {fdc_pkg::PROD_W{1'b1}} / factor) begin
                    sat  = 1'b1;
                    prod = {fdc_pkg::PROD_W{1'b1}};
                end else begin
                    prod = prod * factor;
                end
            end
        end
        res.n         = n_in;
        res.count     = prod;
        res.saturated = sat;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [fdc_pkg::N_W-1:0] n,
                                   input logic [fdc_pkg::PROD_W-1:0] got,
                                   input logic [fdc_pkg::PROD_W-1:0] want);
        $display("mismatch for n=%0d: %s got 0x%0h, wanted 0x%0h", n, what, got, want);
        o_error_count = o_error_count + 1;
    endtask

    // Retire results first, then log the new request
    always @(posedge i_clk) begin
        t_divisor_result want;
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                if (divisor_counts_q.size() == 0) begin
                    report_mismatch("result with nothing pending", '0,
                                    i_m_tdata[fdc_pkg::PROD_W-1:0], '0);
                end else begin
                    want = divisor_counts_q.pop_front();
                    if (i_m_tdata[fdc_pkg::PROD_W-1:0] !== want.count)
                        report_mismatch("divisor_count", want.n,
                                        i_m_tdata[fdc_pkg::PROD_W-1:0], want.count);
                    if (i_m_tdata[fdc_pkg::PROD_W] !== want.saturated)
                        report_mismatch("overflowed", want.n,
                                        fdc_pkg::PROD_W'(i_m_tdata[fdc_pkg::PROD_W]),
                                        fdc_pkg::PROD_W'(want.saturated));
                    if (i_m_tdata[fdc_pkg::OUT_TDATA_W-1:fdc_pkg::PROD_W+1] !== '0)
                        report_mismatch("padding", want.n,
                            fdc_pkg::PROD_W'(
                                i_m_tdata[fdc_pkg::OUT_TDATA_W-1:fdc_pkg::PROD_W+1]),
                            '0);
                end
            end
            if (i_s_tvalid && i_s_tready)
                divisor_counts_q.insert(divisor_counts_q.size(),
                    divisors_of_factorial(i_s_tdata[fdc_pkg::N_W-1:0]));
        end
        o_outstanding <= divisor_counts_q.size();
    end

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the factorial divisor counter. Sends a directed
// set of n (extremes, small cases, values past the 64-bit saturation point)
// followed by random n biased towards small values, with random request
// gaps and result stalls; checking is left to fdc_checker.
// ----------------------------------------------------------------------------
module testbench;

    localparam int RANDOM_ITEMS = 120;
    localparam int QUIET_ITEMS  = 20;
    localparam int DRAIN_CYCLES = 64;

    logic                            clk      = 1'b0;
    logic                            rst_n    = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [fdc_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b1;
    logic [fdc_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            quiet    = 1'b0;
    int                              stall_left = 0;
    int                              error_count;
    int                              outstanding;

    // Extremes, n with no primes, small n and the region where the count saturates
    logic [fdc_pkg::N_W-1:0] corner_n [21] = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6,
                                               8'd7, 8'd8, 8'd16, 8'd31, 8'd32, 8'd64,
                                               8'd85, 8'd100, 8'd127, 8'd128, 8'd170,
                                               8'd200, 8'd254, 8'd255};

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    factorial_divisor_count_top u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    fdc_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .o_error_count (error_count),
        .o_outstanding (outstanding)
    );

    // Result back-pressure: random stall bursts, none started once quiet
    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 2);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // One request, optionally after a random gap with junk on the data lines
    task automatic send_request(input logic [fdc_pkg::N_W-1:0] n_value);
        int gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= fdc_pkg::IN_TDATA_W'($urandom);
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= n_value;
        do @(posedge clk); while (!(s_tvalid && s_tready));
    endtask

    // Random n: mostly small, some anywhere, a few near the top
    function automatic logic [fdc_pkg::N_W-1:0] pick_n();
        case ($urandom_range(0, 9))
            0:       return fdc_pkg::N_W'($urandom_range(200, fdc_pkg::MAX_N));
            1, 2, 3: return fdc_pkg::N_W'($urandom_range(0, fdc_pkg::MAX_N));
            default: return fdc_pkg::N_W'($urandom_range(0, 40));
        endcase
    endfunction

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (corner_n[i])
            send_request(corner_n[i]);
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - QUIET_ITEMS)
                quiet <= 1'b1;
            send_request(pick_n());
        end
        s_tvalid <= 1'b0;
        // wait for every pending result, then let the block settle
        do @(posedge clk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0) begin
            $display("[factorial_divisor_count_top] OK");
        end else begin
            $display("[factorial_divisor_count_top] ERROR");
        end
        $finish;
    end

    // Watchdog, well past the slowest correct run
    initial begin
        #12000000;
        $display("[factorial_divisor_count_top] ERROR");
        $finish;
    end

endmodule
